FILE: sv/atatf_pkg.sv
// Shared types, constants and the opcode table for the ATA taskfile builder.
// Used by every module of the block; depends on nothing.
package atatf_pkg;

   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 88;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_LBA_ENABLED        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LBA48_ENABLED      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PIO_ONLY           = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOST_PIO_FOR_LBA48 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MULTI_COUNT        = 3'd4;

   localparam logic [63:0] LIM28 = 64'd1 << 28;
   localparam logic [16:0] MAX_COUNT28 = 17'd256;
   localparam logic [16:0] MAX_COUNT48 = 17'd65536;
   localparam logic [7:0]  DEVICE_LBA_BIT = 8'h40;

   localparam logic [4:0] BASE_PIO_MULTI = 5'd0;
   localparam logic [4:0] BASE_PIO       = 5'd8;
   localparam logic [4:0] BASE_DMA       = 5'd16;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE_ERR = 2'd1,
      STATUS_NO_OPCODE = 2'd2,
      STATUS_CHS       = 2'd3
   } status_type;

   typedef struct packed {
      logic       lba_enabled;
      logic       lba48_enabled;
      logic       pio_only;
      logic       host_pio_for_lba48;
      logic [7:0] multi_count_setting;
   } cfg_type;

   typedef struct packed {
      logic [63:0] start_block;
      logic [16:0] sector_total;
      logic        is_write;
      logic        force_unit_access;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  command;
      logic        use_dma;
      logic        uses_lba48;
      logic [7:0]  count_low_byte;
      logic [7:0]  count_high_byte;
      logic [23:0] address_low24;
      logic [23:0] address_high24;
      logic [7:0]  device_byte;
   } rsp_type;

   // Rows: PIO multiple, PIO single, DMA. Within a row the index is
   // 4*fua + 2*lba48 + write. A zero entry has no valid opcode.
   function automatic logic [7:0] opcode_lookup(input logic [4:0] idx);
      logic [7:0] op;
      unique case (idx)
         5'd0:    op = 8'hC4;
         5'd1:    op = 8'hC5;
         5'd2:    op = 8'h29;
         5'd3:    op = 8'h39;
         5'd7:    op = 8'hCE;
         5'd8:    op = 8'h20;
         5'd9:    op = 8'h30;
         5'd10:   op = 8'h24;
         5'd11:   op = 8'h34;
         5'd16:   op = 8'hC8;
         5'd17:   op = 8'hCA;
         5'd18:   op = 8'h25;
         5'd19:   op = 8'h35;
         5'd23:   op = 8'h3D;
         default: op = 8'h00;
      endcase
      return op;
   endfunction

endpackage

FILE: sv/atatf_csr.sv
// Configuration registers of the ATA taskfile builder, written through a plain
// write port. Depends on atatf_pkg for the register indexes and cfg_type.
module atatf_csr
   import atatf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_LBA_ENABLED:        cfg_in.lba_enabled         = csr_wdata[0];
            CSR_LBA48_ENABLED:      cfg_in.lba48_enabled       = csr_wdata[0];
            CSR_PIO_ONLY:           cfg_in.pio_only            = csr_wdata[0];
            CSR_HOST_PIO_FOR_LBA48: cfg_in.host_pio_for_lba48  = csr_wdata[0];
            CSR_MULTI_COUNT:        cfg_in.multi_count_setting = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lba_enabled         <= 1'b1;
         cfg_ff.lba48_enabled       <= 1'b0;
         cfg_ff.pio_only            <= 1'b0;
         cfg_ff.host_pio_for_lba48  <= 1'b0;
         cfg_ff.multi_count_setting <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/atatf_encode.sv
// Combinational encoder from one read/write request to one ATA taskfile:
// range checks, mode and protocol choice, opcode lookup. Depends on atatf_pkg.
module atatf_encode
   import atatf_pkg::*;
(
   input  cfg_type cfg,
   input  req_type req,
   output rsp_type rsp
);

   logic [28:0] sum28;
   logic [49:0] sum48;
   logic        fits28;
   logic        fits48;
   logic        start_le48;
   logic        end_le48;
   logic        wide;
   logic        dma;
   logic [4:0]  base;
   logic [4:0]  idx;
   logic [7:0]  opcode;

   always_comb begin
      sum28 = {1'b0, req.start_block[27:0]} + {12'd0, req.sector_total};
      sum48 = {1'b0, req.start_block[48:0]} + {33'd0, req.sector_total};

      fits28 = (req.start_block[63:28] == 36'd0) && !sum28[28]
               && (req.sector_total <= MAX_COUNT28);

      // The whole range must end at or below 2^48.
      start_le48 = (req.start_block[63:49] == 15'd0)
                   && (!req.start_block[48] || (req.start_block[47:0] == 48'd0));
      end_le48   = !sum48[49] && (!sum48[48] || (sum48[47:0] == 48'd0));
      fits48     = start_le48 && end_le48 && (req.sector_total <= MAX_COUNT48);

      wide = !fits28;
      dma  = !(cfg.pio_only || (wide && cfg.host_pio_for_lba48));
      if (dma) begin
         base = BASE_DMA;
      end else if (cfg.multi_count_setting != 8'd0) begin
         base = BASE_PIO_MULTI;
      end else begin
         base = BASE_PIO;
      end
      idx    = base + {2'b00, req.force_unit_access, wide, req.is_write};
      opcode = opcode_lookup(idx);

      rsp = '0;
      priority if (!cfg.lba_enabled) begin
         rsp.status = STATUS_CHS;
      end else if (!fits28 && !(fits48 && cfg.lba48_enabled)) begin
         rsp.status = STATUS_RANGE_ERR;
      end else if (opcode == 8'h00) begin
         rsp.status = STATUS_NO_OPCODE;
      end else begin
         rsp.status         = STATUS_OK;
         rsp.command        = opcode;
         rsp.use_dma        = dma;
         rsp.uses_lba48     = wide;
         rsp.count_low_byte = req.sector_total[7:0];
         rsp.address_low24  = req.start_block[23:0];
         if (wide) begin
            rsp.count_high_byte = req.sector_total[15:8];
            rsp.address_high24  = req.start_block[47:24];
            rsp.device_byte     = DEVICE_LBA_BIT;
         end else begin
            rsp.device_byte = DEVICE_LBA_BIT | {4'd0, req.start_block[27:24]};
         end
      end
   end

endmodule

FILE: sv/ata_rw_taskfile_builder.sv
// Top level of the ATA read/write taskfile builder: request register, encoder,
// result register. Depends on atatf_pkg, atatf_csr and atatf_encode.
//
// Usage: each request on the req_ stream carries a start block and a sector
// count in req_tdata and the write and FUA flags in req_tuser. For each
// request the block returns exactly one taskfile on the rsp_ stream with a
// status code, the opcode, the protocol and addressing flags and the
// taskfile bytes. Requests that fail (CHS device, range error, no opcode)
// return the status with all other fields zero.
// The request register loads at the accepting edge and the result register
// loads from the encoder once it is empty or its taskfile is being taken.
// Throughput is one request per cycle while the receiver does not stall; the
// encoder is a single pass of short logic between the two registers.
// When the receiver stalls, the result register holds its taskfile and the
// request register can still take one more request; req_tready drops only
// when both are full. Reset empties both registers and loads the default
// configuration (LBA on, 48-bit off, DMA allowed, multiple mode off).
// Configuration is to be written through csr_ only while no request is in
// flight; the user must keep to this, as the block does not enforce it.
module ata_rw_taskfile_builder
   import atatf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: start_block [63:0], sector_total [80:64], zero pad above.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: is_write [0], force_unit_access [1].
   input  logic [REQ_USER_W-1:0] req_tuser,
   // rsp_tdata: status [1:0], command [9:2], use_dma [10], uses_lba48 [11],
   // count_low_byte [19:12], count_high_byte [27:20], address_low24 [51:28],
   // address_high24 [75:52], device_byte [83:76], zero pad above.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   req_type req_ff;
   req_type req_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    req_valid_ff;
   logic    req_valid_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    req_accept;
   logic    advance;

   atatf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   atatf_encode u_encode (
      .cfg (cfg),
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      req_in.start_block       = req_tdata[63:0];
      req_in.sector_total      = req_tdata[80:64];
      req_in.is_write          = req_tuser[0];
      req_in.force_unit_access = req_tuser[1];
      req_valid_in = req_accept || (req_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.device_byte, rsp_ff.address_high24,
                        rsp_ff.address_low24, rsp_ff.count_high_byte,
                        rsp_ff.count_low_byte, rsp_ff.uses_lba48, rsp_ff.use_dma,
                        rsp_ff.command, rsp_ff.status};

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("result register not empty after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_valid_ff)
      else $error("accepted request lost from request register");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_ff.status != STATUS_OK) |-> (rsp_tdata[83:2] == 82'd0))
      else $error("failed taskfile carries nonzero fields");

   a_narrow_high_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_ff.status == STATUS_OK) && !rsp_ff.uses_lba48
      |-> (rsp_ff.count_high_byte == 8'd0) && (rsp_ff.address_high24 == 24'd0))
      else $error("28-bit taskfile carries high-order bytes");

endmodule

FILE: test/taskfile_checker.sv
// Checker for the ATA read/write taskfile builder: tracks configuration writes,
// predicts one taskfile per accepted request and compares every returned one.
// Depends on atatf_pkg for the port widths, register indexes and result types.
module taskfile_checker
   import atatf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    awaiting,
   output int                    mismatch_count,
   output int                    checked_count
);

   localparam logic [64:0] LBA28_END = 65'd1 << 28;
   localparam logic [64:0] LBA48_END = 65'd1 << 48;
   localparam int REPORT_LIMIT = 10;

   localparam logic [7:0] OPCODE_TABLE [0:23] = '{
      8'hC4, 8'hC5, 8'h29, 8'h39, 8'h00, 8'h00, 8'h00, 8'hCE,
      8'h20, 8'h30, 8'h24, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00,
      8'hC8, 8'hCA, 8'h25, 8'h35, 8'h00, 8'h00, 8'h00, 8'h3D
   };

   cfg_type cfg_copy;
   rsp_type expected_taskfiles [$];
   rsp_type want_tf;
   rsp_type got_tf;

   function automatic rsp_type predict_taskfile(input cfg_type cfg, input logic [63:0] block,
                                                input logic [16:0] count, input logic wr,
                                                input logic fua);
      rsp_type tf;
      logic [64:0] range_end;
      logic fits28;
      logic fits48;
      logic wide;
      logic dma;
      logic [4:0] slot;
      logic [7:0] op;
      tf = '0;
      if (!cfg.lba_enabled) begin
         tf.status = STATUS_CHS;
         return tf;
      end
      range_end = {1'b0, block} + 65'(count);
      fits28 = ({1'b0, block} < LBA28_END) && (range_end < LBA28_END)
               && (count <= MAX_COUNT28);
      fits48 = ({1'b0, block} <= LBA48_END) && (range_end <= LBA48_END)
               && (count <= MAX_COUNT48);
      if (fits28) begin
         wide = 1'b0;
      end else if (fits48 && cfg.lba48_enabled) begin
         wide = 1'b1;
      end else begin
         tf.status = STATUS_RANGE_ERR;
         return tf;
      end
      if (cfg.pio_only || (wide && cfg.host_pio_for_lba48)) begin
         dma = 1'b0;
         slot = (cfg.multi_count_setting != 8'd0) ? BASE_PIO_MULTI : BASE_PIO;
      end else begin
         dma = 1'b1;
         slot = BASE_DMA;
      end
      slot = slot + 5'({fua, wide, wr});
      op = OPCODE_TABLE[slot];
      if (op == 8'h00) begin
         tf.status = STATUS_NO_OPCODE;
         return tf;
      end
      tf.status = STATUS_OK;
      tf.command = op;
      tf.use_dma = dma;
      tf.uses_lba48 = wide;
      tf.count_low_byte = count[7:0];
      tf.count_high_byte = wide ? count[15:8] : 8'd0;
      tf.address_low24 = block[23:0];
      tf.address_high24 = wide ? block[47:24] : 24'd0;
      tf.device_byte = DEVICE_LBA_BIT | (wide ? 8'd0 : {4'd0, block[27:24]});
      return tf;
   endfunction

   function automatic rsp_type unpack_taskfile(input logic [RSP_DATA_W-1:0] d);
      rsp_type tf;
      tf.status = status_type'(d[1:0]);
      tf.command = d[9:2];
      tf.use_dma = d[10];
      tf.uses_lba48 = d[11];
      tf.count_low_byte = d[19:12];
      tf.count_high_byte = d[27:20];
      tf.address_low24 = d[51:28];
      tf.address_high24 = d[75:52];
      tf.device_byte = d[83:76];
      return tf;
   endfunction

   task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("Taskfile %0d, %s: expected %h, got %h", checked_count, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_copy = '0;
         cfg_copy.lba_enabled = 1'b1;
         expected_taskfiles.delete();
         awaiting <= 0;
         mismatch_count = 0;
         checked_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_addr)
               CSR_LBA_ENABLED:        cfg_copy.lba_enabled = csr_wdata[0];
               CSR_LBA48_ENABLED:      cfg_copy.lba48_enabled = csr_wdata[0];
               CSR_PIO_ONLY:           cfg_copy.pio_only = csr_wdata[0];
               CSR_HOST_PIO_FOR_LBA48: cfg_copy.host_pio_for_lba48 = csr_wdata[0];
               CSR_MULTI_COUNT:        cfg_copy.multi_count_setting = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_taskfiles.push_back(predict_taskfile(cfg_copy, req_tdata[63:0],
                                                          req_tdata[80:64], req_tuser[0],
                                                          req_tuser[1]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_taskfiles.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("Taskfile %h arrived with no request waiting", rsp_tdata);
            end else begin
               want_tf = expected_taskfiles.pop_front();
               got_tf = unpack_taskfile(rsp_tdata);
               check_field("status", 24'(want_tf.status), 24'(got_tf.status));
               check_field("command", 24'(want_tf.command), 24'(got_tf.command));
               check_field("use_dma", 24'(want_tf.use_dma), 24'(got_tf.use_dma));
               check_field("uses_lba48", 24'(want_tf.uses_lba48), 24'(got_tf.uses_lba48));
               check_field("count_low_byte", 24'(want_tf.count_low_byte),
                           24'(got_tf.count_low_byte));
               check_field("count_high_byte", 24'(want_tf.count_high_byte),
                           24'(got_tf.count_high_byte));
               check_field("address_low24", want_tf.address_low24, got_tf.address_low24);
               check_field("address_high24", want_tf.address_high24, got_tf.address_high24);
               check_field("device_byte", 24'(want_tf.device_byte), 24'(got_tf.device_byte));
               check_field("padding", 24'd0, 24'(rsp_tdata[RSP_DATA_W-1:84]));
               checked_count++;
            end
         end
         awaiting <= expected_taskfiles.size();
      end
   end

endmodule

FILE: test/testbench.sv
// Top of the taskfile builder testbench: clock, reset, configuration phases,
// directed and random requests with idling and back-pressure, and the verdict.
// Depends on atatf_pkg, ata_rw_taskfile_builder and taskfile_checker.
module testbench;
   import atatf_pkg::*;

   localparam logic [63:0] LBA48_TOP = 64'd1 << 48;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PRESSURE_PHASE = 4;
   localparam int HOLD_CYCLES = 300;
   localparam int LATENCY_PAD = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HEAVY_IDLE = 83;
   localparam int LIGHT_IDLE = 29;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int awaiting;
   int mismatch_count;
   int checked_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int cycle_count = 0;
   bit hold_pending = 1'b0;

   ata_rw_taskfile_builder u_dut (.*);
   taskfile_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver normally stalls at random; a long hold-off fills the block.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic req_type make_request(input logic [63:0] block, input logic [16:0] count,
                                            input logic wr, input logic fua);
      req_type r;
      r.start_block = block;
      r.sector_total = count;
      r.is_write = wr;
      r.force_unit_access = fua;
      return r;
   endfunction

   function automatic req_type random_request();
      logic [63:0] block;
      logic [16:0] count;
      case ($urandom_range(9))
         0, 1, 2, 3: block = 64'($urandom_range(32'h0FFF_FFFF));
         4:          block = LIM28 - 64'($urandom_range(300));
         5, 6:       block = {16'd0, 16'($urandom), $urandom};
         7:          block = LBA48_TOP - 64'($urandom_range(70000)) + 64'($urandom_range(1));
         8:          block = {$urandom, $urandom};
         default:    block = '1 - 64'($urandom_range(70000));
      endcase
      case ($urandom_range(7))
         0, 1, 2, 3, 4: count = 17'($urandom_range(256));
         5:             count = 17'($urandom_range(65536));
         6:             count = MAX_COUNT48 - 17'($urandom_range(3));
         default:       count = 17'($urandom);
      endcase
      return make_request(block, count, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'({r.sector_total, r.start_block});
      req_tuser <= {r.force_unit_access, r.is_write};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input bit lba, input bit lba48, input bit pio, input bit host_pio,
                            input logic [7:0] multi);
      write_csr(CSR_LBA_ENABLED, {7'd0, lba});
      write_csr(CSR_LBA48_ENABLED, {7'd0, lba48});
      write_csr(CSR_PIO_ONLY, {7'd0, pio});
      write_csr(CSR_HOST_PIO_FOR_LBA48, {7'd0, host_pio});
      write_csr(CSR_MULTI_COUNT, multi);
   endtask

   initial begin
      logic [7:0] multi;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: 28-bit DMA only.
      send_request(make_request(64'd0, 17'd0, 1'b0, 1'b0));
      send_request(make_request(LIM28 - 64'd257, MAX_COUNT28, 1'b1, 1'b0));
      send_request(make_request(LIM28 - 64'd1, 17'd0, 1'b0, 1'b0));
      send_request(make_request(LIM28 - 64'd1, 17'd1, 1'b1, 1'b0));
      send_request(make_request(64'd0, MAX_COUNT28 + 17'd1, 1'b0, 1'b0));
      send_request(make_request(64'd5, 17'd8, 1'b0, 1'b1));
      send_request(make_request('1, MAX_COUNT48, 1'b1, 1'b1));
      drain();

      // Writes to unused indexes must leave the configuration alone.
      for (int a = int'(CSR_MULTI_COUNT) + 1; a < (1 << CSR_ADDR_W); a++)
         write_csr(CSR_ADDR_W'(a), '1);
      write_csr(CSR_LBA48_ENABLED, 8'd1);
      send_request(make_request(LBA48_TOP, 17'd0, 1'b1, 1'b0));
      send_request(make_request(LBA48_TOP - 64'd65536, MAX_COUNT48, 1'b1, 1'b1));
      send_request(make_request(LBA48_TOP, 17'd1, 1'b0, 1'b0));
      send_request(make_request('1, 17'd1, 1'b0, 1'b0));
      send_request(make_request(64'd0, '1, 1'b1, 1'b0));
      send_request(make_request(LIM28, 17'd300, 1'b0, 1'b1));
      drain();

      write_csr(CSR_HOST_PIO_FOR_LBA48, 8'd1);
      send_request(make_request(LIM28, 17'd16, 1'b0, 1'b0));
      send_request(make_request(LIM28 + 64'd9, 17'd2, 1'b1, 1'b1));
      send_request(make_request(64'h0ABC_DEF1, 17'd3, 1'b0, 1'b0));
      drain();

      configure(1'b1, 1'b1, 1'b1, 1'b0, 8'd255);
      send_request(make_request(64'h0123_4567, 17'd255, 1'b0, 1'b0));
      send_request(make_request(64'h0765_4321, 17'd4, 1'b1, 1'b0));
      send_request(make_request(64'h0000_FFFF_FFFF_0000, 17'd512, 1'b1, 1'b1));
      send_request(make_request(64'h0000_8000_0000_0000, 17'd7, 1'b0, 1'b0));
      drain();
      write_csr(CSR_MULTI_COUNT, 8'd1);
      send_request(make_request(64'h0000_5555_AAAA_5555, 17'd1000, 1'b1, 1'b0));
      drain();
      write_csr(CSR_LBA_ENABLED, 8'd0);
      send_request(make_request(64'd0, 17'd1, 1'b0, 1'b0));
      send_request(make_request('1, '1, 1'b1, 1'b1));
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            configure(1'b1, 1'b1, 1'b1, 1'b1, 8'd255);
         end else if (p == 1) begin
            configure(1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
         end else if (p == 2) begin
            configure(1'b1, 1'b0, 1'b0, 1'b0, 8'd0);
         end else begin
            case ($urandom_range(3))
               0:       multi = 8'd0;
               1:       multi = 8'd255;
               default: multi = 8'($urandom_range(255));
            endcase
            configure($urandom_range(7) != 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), multi);
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = HEAVY_IDLE;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = HEAVY_IDLE;
            end
            default: begin
               send_idle_pct = LIGHT_IDLE;
               stall_pct = LIGHT_IDLE;
            end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == PRESSURE_PHASE && i == 10)
               hold_pending = 1'b1;
            send_request(random_request());
         end
         drain();
      end

      repeat (LATENCY_PAD) @(posedge clock);
      $display("Sent %0d requests across %0d random configuration phases plus directed cases;",
               sent_count, RANDOM_PHASES);
      $display("%0d taskfiles were compared, with idling, stalls and one long hold-off.",
               checked_count);
      if (mismatch_count == 0 && awaiting == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: ata_rw_taskfile_builder.f
sv/atatf_pkg.sv
sv/atatf_csr.sv
sv/atatf_encode.sv
sv/ata_rw_taskfile_builder.sv
test/taskfile_checker.sv
test/testbench.sv
